// ===== sv/stroke_coverage_mask_unit_defines.svh =====
// Assertion macros for the stroke coverage mask unit.
// Expects clk and rst_n in the scope of every use.
`ifndef STROKE_COVERAGE_MASK_UNIT_DEFINES_SVH
`define STROKE_COVERAGE_MASK_UNIT_DEFINES_SVH

// same-cycle implication
`define SCM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/scm_pkg.sv =====
// Shared constants, codes and types of the stroke coverage mask unit.
// No dependencies; used by the interfaces, the mask RAM and the sequencer.
package scm_pkg;

  localparam int SCM_MAX_WIDTH  = 512;
  localparam int SCM_MAX_HEIGHT = 512;
  localparam int SCM_MAX_SQUARE = 32;

  localparam int FUNC_W    = 2;
  localparam int POS_W     = 11;
  localparam int SIZE_W    = 6;
  localparam int BOX_W     = 10;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;

  // signed geometry width: covers anchors, stamp extents and canvases up to 8191
  localparam int GEO_W = 14;

  localparam int CANVAS_RST = 512;

  localparam logic [FUNC_W-1:0] FUNC_STAMP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PROBE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_W = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_H = 1'b1;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } scm_ram_ctl_t;

endpackage

// ===== sv/scm_in_if.sv =====
// Input channel of the stroke coverage mask unit: valid/ready plus one item.
// Depends on scm_pkg for field widths.
interface scm_in_if;
  import scm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic [SIZE_W-1:0]        square_size;

  modport source (output valid, func, pos_x, pos_y, square_size, input ready);
  modport sink   (input valid, func, pos_x, pos_y, square_size, output ready);
endinterface

// ===== sv/scm_out_if.sv =====
// Result channel of the stroke coverage mask unit: valid/ready plus one result.
// Depends on scm_pkg for field widths.
interface scm_out_if;
  import scm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     covered;
  logic                     box_empty;
  logic [BOX_W-1:0]         box_left;
  logic [BOX_W-1:0]         box_top;
  logic signed [BOX_W-1:0]  box_right;
  logic signed [BOX_W-1:0]  box_bottom;

  modport source (output valid, covered, box_empty, box_left, box_top, box_right,
                  box_bottom, input ready);
  modport sink   (input valid, covered, box_empty, box_left, box_top, box_right,
                  box_bottom, output ready);
endinterface

// ===== sv/scm_mask_ram.sv =====
// Coverage mask storage: one row of pixels per entry, one write and one read port.
// Registered read data, valid in the cycle after the read. Depends on scm_pkg.
module scm_mask_ram #(
  parameter int DEPTH = scm_pkg::SCM_MAX_HEIGHT,
  parameter int WIDTH = scm_pkg::SCM_MAX_WIDTH
) (
  input  logic                       clk,
  input  scm_pkg::scm_ram_ctl_t      ctl,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [WIDTH-1:0]           rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

endmodule

// ===== sv/scm_seq.sv =====
// Sequencer of the stroke coverage mask unit: item decode, clipping, dirty box,
// row read-modify-write loop, probe read, wipe pass and result register. Depends on scm_pkg.
`include "stroke_coverage_mask_unit_defines.svh"
module scm_seq #(
  parameter int MAX_WIDTH  = scm_pkg::SCM_MAX_WIDTH,
  parameter int MAX_HEIGHT = scm_pkg::SCM_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  scm_in_if.sink                             in_ch,
  scm_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [scm_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [scm_pkg::CFG_W-1:0]          cfg_wdata,
  output scm_pkg::scm_ram_ctl_t              ram_ctl,
  output logic [$clog2(MAX_HEIGHT)-1:0]      wr_addr,
  output logic [MAX_WIDTH-1:0]               wr_data,
  output logic [$clog2(MAX_HEIGHT)-1:0]      rd_addr,
  input  logic [MAX_WIDTH-1:0]               rd_data
);
  import scm_pkg::*;

  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int CW = $clog2(MAX_WIDTH);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_WIPE   = 8'b0000_0010,
    ST_GEOM   = 8'b0000_0100,
    ST_MASK   = 8'b0000_1000,
    ST_RUN    = 8'b0001_0000,
    ST_PROBE  = 8'b0010_0000,
    ST_PRB_RD = 8'b0100_0000,
    ST_FIN    = 8'b1000_0000
  } scm_state_t;

  typedef logic signed [GEO_W-1:0] geo_t;

  function automatic geo_t clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
    geo_t res;
    if (v == '0) begin
      res = GEO_W'(1);
    end else if (int'(v) > maxv) begin
      res = GEO_W'(maxv);
    end else begin
      res = GEO_W'(v);
    end
    return res;
  endfunction

  // control state
  scm_state_t       state_r, state_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic             rd_active_r, rd_active_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  geo_t             canvas_w_r, canvas_w_nxt;
  geo_t             canvas_h_r, canvas_h_nxt;
  geo_t             box_l_r, box_l_nxt;
  geo_t             box_t_r, box_t_nxt;
  geo_t             box_rt_r, box_rt_nxt;
  geo_t             box_b_r, box_b_nxt;

  // payload
  logic [FUNC_W-1:0]  func_r, func_nxt;
  geo_t               px_r, px_nxt;
  geo_t               py_r, py_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic               op_clr_r, op_clr_nxt;
  logic [CW-1:0]      col_lo_r, col_lo_nxt;
  logic [CW-1:0]      col_hi_r, col_hi_nxt;
  logic [RW-1:0]      row_end_r, row_end_nxt;
  logic [RW-1:0]      wr_row_r, wr_row_nxt;
  logic [MAX_WIDTH-1:0] col_mask_r, col_mask_nxt;
  logic               covered_r, covered_nxt;
  logic               out_covered_r, out_covered_nxt;
  logic               out_empty_r, out_empty_nxt;
  logic [BOX_W-1:0]   out_l_r, out_l_nxt;
  logic [BOX_W-1:0]   out_t_r, out_t_nxt;
  logic [BOX_W-1:0]   out_rt_r, out_rt_nxt;
  logic [BOX_W-1:0]   out_b_r, out_b_nxt;

  // stamp geometry
  geo_t sz, sz_m1, half, hi_off;
  geo_t x0, x1, y0, y1, x0c, x1c, y0c, y1c;
  logic hit, in_canvas, box_empty;
  logic in_acc;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  assign sz     = (int'(size_r) > SCM_MAX_SQUARE) ? GEO_W'(SCM_MAX_SQUARE) : GEO_W'(size_r);
  assign sz_m1  = sz - GEO_W'(1);
  assign half   = sz_m1 >>> 1;
  assign hi_off = sz_m1 - half;
  assign x0     = px_r - half;
  assign y0     = py_r - half;
  assign x1     = px_r + hi_off;
  assign y1     = py_r + hi_off;
  assign x0c    = (x0 < 0) ? '0 : x0;
  assign y0c    = (y0 < 0) ? '0 : y0;
  assign x1c    = (x1 >= canvas_w_r) ? canvas_w_r - GEO_W'(1) : x1;
  assign y1c    = (y1 >= canvas_h_r) ? canvas_h_r - GEO_W'(1) : y1;
  assign hit    = (size_r != '0) && (x0c <= x1c) && (y0c <= y1c);
  assign in_canvas = (px_r >= 0) && (py_r >= 0) && (px_r < canvas_w_r) && (py_r < canvas_h_r);
  assign box_empty = (box_rt_r < box_l_r) || (box_b_r < box_t_r);

  // memory port
  always_comb begin
    ram_ctl.rd_en = ((state_r == ST_RUN) && rd_active_r) || (state_r == ST_PROBE);
    ram_ctl.wr_en = (state_r == ST_WIPE) || ((state_r == ST_RUN) && pend_r);
    rd_addr = (state_r == ST_PROBE) ? py_r[RW-1:0] : row_r;
    wr_addr = (state_r == ST_WIPE) ? row_r : wr_row_r;
    if (state_r == ST_WIPE) begin
      wr_data = '0;
    end else if (op_clr_r) begin
      wr_data = rd_data & ~col_mask_r;
    end else begin
      wr_data = rd_data | col_mask_r;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    row_nxt         = row_r;
    rd_active_nxt   = rd_active_r;
    pend_nxt        = pend_r;
    out_valid_nxt   = out_valid_r;
    canvas_w_nxt    = canvas_w_r;
    canvas_h_nxt    = canvas_h_r;
    box_l_nxt       = box_l_r;
    box_t_nxt       = box_t_r;
    box_rt_nxt      = box_rt_r;
    box_b_nxt       = box_b_r;
    func_nxt        = func_r;
    px_nxt          = px_r;
    py_nxt          = py_r;
    size_nxt        = size_r;
    op_clr_nxt      = op_clr_r;
    col_lo_nxt      = col_lo_r;
    col_hi_nxt      = col_hi_r;
    row_end_nxt     = row_end_r;
    wr_row_nxt      = wr_row_r;
    col_mask_nxt    = col_mask_r;
    covered_nxt     = covered_r;
    out_covered_nxt = out_covered_r;
    out_empty_nxt   = out_empty_r;
    out_l_nxt       = out_l_r;
    out_t_nxt       = out_t_r;
    out_rt_nxt      = out_rt_r;
    out_b_nxt       = out_b_r;

    // drop the result once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          func_nxt    = in_ch.func;
          px_nxt      = GEO_W'(in_ch.pos_x);
          py_nxt      = GEO_W'(in_ch.pos_y);
          size_nxt    = in_ch.square_size;
          covered_nxt = 1'b0;
          state_nxt   = ST_GEOM;
        end
      end
      ST_WIPE: begin
        if (int'(row_r) == MAX_HEIGHT - 1) begin
          state_nxt = ST_IDLE;
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end
      ST_GEOM: begin
        state_nxt = ST_FIN;
        if (func_r == FUNC_STAMP) begin
          if (hit) begin
            op_clr_nxt  = 1'b0;
            col_lo_nxt  = x0c[CW-1:0];
            col_hi_nxt  = x1c[CW-1:0];
            row_nxt     = y0c[RW-1:0];
            row_end_nxt = y1c[RW-1:0];
            box_l_nxt   = (x0c < box_l_r) ? x0c : box_l_r;
            box_t_nxt   = (y0c < box_t_r) ? y0c : box_t_r;
            box_rt_nxt  = (x1c > box_rt_r) ? x1c : box_rt_r;
            box_b_nxt   = (y1c > box_b_r) ? y1c : box_b_r;
            state_nxt   = ST_MASK;
          end
        end else if (func_r == FUNC_CLEAR) begin
          if (!box_empty) begin
            op_clr_nxt  = 1'b1;
            col_lo_nxt  = box_l_r[CW-1:0];
            col_hi_nxt  = box_rt_r[CW-1:0];
            row_nxt     = box_t_r[RW-1:0];
            row_end_nxt = box_b_r[RW-1:0];
            state_nxt   = ST_MASK;
          end
          box_l_nxt  = canvas_w_r;
          box_t_nxt  = canvas_h_r;
          box_rt_nxt = -GEO_W'(1);
          box_b_nxt  = -GEO_W'(1);
        end else if (func_r == FUNC_PROBE) begin
          if (in_canvas) begin
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_MASK: begin
        col_mask_nxt  = ({MAX_WIDTH{1'b1}} << col_lo_r)
                      & ({MAX_WIDTH{1'b1}} >> (CW'(MAX_WIDTH - 1) - col_hi_r));
        rd_active_nxt = 1'b1;
        pend_nxt      = 1'b0;
        state_nxt     = ST_RUN;
      end
      ST_RUN: begin
        pend_nxt   = rd_active_r;
        wr_row_nxt = row_r;
        if (rd_active_r) begin
          if (row_r == row_end_r) begin
            rd_active_nxt = 1'b0;
          end else begin
            row_nxt = row_r + RW'(1);
          end
        end
        if (!rd_active_r && !pend_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_PROBE: begin
        state_nxt = ST_PRB_RD;
      end
      ST_PRB_RD: begin
        covered_nxt = rd_data[px_r[CW-1:0]];
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_covered_nxt = covered_r;
          out_empty_nxt   = box_empty;
          out_l_nxt       = BOX_W'(box_l_r);
          out_t_nxt       = BOX_W'(box_t_r);
          out_rt_nxt      = BOX_W'(box_rt_r);
          out_b_nxt       = BOX_W'(box_b_r);
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // canvas write: new size, empty box, wipe the mask
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_CANVAS_W: canvas_w_nxt = clamp_dim(cfg_wdata, MAX_WIDTH);
        CFG_CANVAS_H: canvas_h_nxt = clamp_dim(cfg_wdata, MAX_HEIGHT);
        default: ;
      endcase
      box_l_nxt     = canvas_w_nxt;
      box_t_nxt     = canvas_h_nxt;
      box_rt_nxt    = -GEO_W'(1);
      box_b_nxt     = -GEO_W'(1);
      rd_active_nxt = 1'b0;
      pend_nxt      = 1'b0;
      row_nxt       = '0;
      state_nxt     = ST_WIPE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WIPE;
      row_r       <= '0;
      rd_active_r <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      canvas_w_r  <= clamp_dim(CFG_W'(CANVAS_RST), MAX_WIDTH);
      canvas_h_r  <= clamp_dim(CFG_W'(CANVAS_RST), MAX_HEIGHT);
      box_l_r     <= clamp_dim(CFG_W'(CANVAS_RST), MAX_WIDTH);
      box_t_r     <= clamp_dim(CFG_W'(CANVAS_RST), MAX_HEIGHT);
      box_rt_r    <= -GEO_W'(1);
      box_b_r     <= -GEO_W'(1);
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      rd_active_r <= rd_active_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      canvas_w_r  <= canvas_w_nxt;
      canvas_h_r  <= canvas_h_nxt;
      box_l_r     <= box_l_nxt;
      box_t_r     <= box_t_nxt;
      box_rt_r    <= box_rt_nxt;
      box_b_r     <= box_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r        <= func_nxt;
    px_r          <= px_nxt;
    py_r          <= py_nxt;
    size_r        <= size_nxt;
    op_clr_r      <= op_clr_nxt;
    col_lo_r      <= col_lo_nxt;
    col_hi_r      <= col_hi_nxt;
    row_end_r     <= row_end_nxt;
    wr_row_r      <= wr_row_nxt;
    col_mask_r    <= col_mask_nxt;
    covered_r     <= covered_nxt;
    out_covered_r <= out_covered_nxt;
    out_empty_r   <= out_empty_nxt;
    out_l_r       <= out_l_nxt;
    out_t_r       <= out_t_nxt;
    out_rt_r      <= out_rt_nxt;
    out_b_r       <= out_b_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.covered    = out_covered_r;
  assign out_ch.box_empty  = out_empty_r;
  assign out_ch.box_left   = out_l_r;
  assign out_ch.box_top    = out_t_r;
  assign out_ch.box_right  = out_rt_r;
  assign out_ch.box_bottom = out_b_r;

  `SCM_ASSERT_IMP(a_rmw_no_overlap, ram_ctl.wr_en && ram_ctl.rd_en, wr_addr != rd_addr, "read and write hit the same mask row")
  `SCM_ASSERT_IMP(a_run_in_range, (state_r == ST_RUN) && rd_active_r, row_r <= row_end_r, "row walk passed its last row")
  `SCM_ASSERT_NXT(a_fin_holds, (state_r == ST_FIN) && out_valid_r && !out_ch.ready && !cfg_we, (state_r == ST_FIN) && out_valid_r, "finished result overwrote a waiting beat")
  `SCM_ASSERT_IMP(a_wipe_blocks, (state_r == ST_WIPE) || (state_r == ST_RUN), !in_ch.ready, "item taken during mask update")

endmodule

// ===== sv/stroke_coverage_mask_unit.sv =====
// From accept to result valid: a stamp or clear that touches the mask passes decode,
// mask build, one row read-modified-written per cycle, drain and load; a probe inside
// the canvas passes decode, row read and load; any other item, decode and load. A held
// result adds its stall. One item at a time: the next is taken once its result loads.
// Reset (and every canvas write) runs a wipe pass over the mask memory, one row per cycle,
// during which no item is accepted.
module stroke_coverage_mask_unit #(
  parameter int MAX_WIDTH  = scm_pkg::SCM_MAX_WIDTH,
  parameter int MAX_HEIGHT = scm_pkg::SCM_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  scm_in_if.sink                         in_ch,
  scm_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [scm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [scm_pkg::CFG_W-1:0]      cfg_wdata
);
  import scm_pkg::*;

  scm_ram_ctl_t                   ram_ctl;
  logic [$clog2(MAX_HEIGHT)-1:0]  wr_addr;
  logic [$clog2(MAX_HEIGHT)-1:0]  rd_addr;
  logic [MAX_WIDTH-1:0]           wr_data;
  logic [MAX_WIDTH-1:0]           rd_data;

  scm_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .ram_ctl   (ram_ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  scm_mask_ram #(
    .DEPTH (MAX_HEIGHT),
    .WIDTH (MAX_WIDTH)
  ) u_mask_ram (
    .clk       (clk),
    .ctl       (ram_ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

endmodule
